/* design/dwnf_pkg.sv */
// Shared constants and types for the wildcard name filter.
// Used by dwnf_front, dwnf_queue, dwnf_back and dos_wildcard_name_filter.
`timescale 1ns / 1ps
`default_nettype none

package dwnf_pkg;

    localparam int PATTERN_BYTES = 16;
    localparam int POS_W         = $clog2(PATTERN_BYTES + 1);

    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CHAR_STAR  = 8'h2A;
    localparam logic [7:0] CHAR_QMARK = 8'h3F;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_NUL   = 8'h00;

    localparam logic [15:0] MODE_TYPE = 16'hF000;
    localparam logic [15:0] MODE_REG  = 16'h8000;
    localparam logic [2:0]  PERM_ANY  = 3'o7;
    localparam logic [2:0]  PERM_READ = 3'o4;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_FLAGS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_USER_ID      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GROUP_ID     = 3'd4;

    localparam int FLAG_HIDE_DOT = 0;
    localparam int FLAG_MINE     = 1;
    localparam int FLAG_ACCESS   = 2;
    localparam int FLAG_REGULAR  = 3;
    localparam int FLAG_READ     = 4;

    typedef struct packed {
        logic [4:0]  flags;
        logic [31:0] user_id;
        logic [31:0] group_id;
    } filter_cfg_t;

    typedef struct packed {
        logic [7:0] name_char;
        logic       is_last;
        logic       pass;
    } entry_t;

endpackage

`default_nettype wire

/* design/dos_wildcard_name_filter.sv */
// Wildcard file-name filter, top level: configuration registers, front end,
// queue and matcher. Depends on dwnf_pkg, dwnf_front, dwnf_queue, dwnf_back.
//
// Usage:
//   s_* channel: one file-name byte per transaction, s_tlast on the last
//   byte. File attributes ride with every byte but are used on the last.
//   m_* channel: one transaction per name, after its last byte.
//   cfg_* channel: register writes, always ready; write only while idle.
// Timing:
//   Each byte leaves the queue into the matcher (IDLE), which then steps the
//   pattern (FEED): one step for a plain byte, more when a star meets a dot
//   and the pattern is skipped to its next dot, one position a cycle. The
//   last byte adds finish steps (FIN, TAIL, DOT) and a result step (RES).
//   The matcher state machine sets the rate: it takes no new byte until IDLE.
// Reset: synchronous, active low; config registers and control state cleared, pattern empty.
// Stall: a result waits in the output register while m_tready is low; the
//   queue keeps taking bytes until it fills, then s_tready drops.
`timescale 1ns / 1ps
`default_nettype none

module dos_wildcard_name_filter (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            s_tvalid,
    output logic                           s_tready,
    // name_char[7:0], file_mode[23:8], owner_uid[55:24], owner_gid[87:56]
    input  wire  [87:0]                    s_tdata,
    input  wire                            s_tlast,
    // attr_valid[0]
    input  wire                            s_tuser,
    output logic                           m_tvalid,
    input  wire                            m_tready,
    // name_matches[0], accepted[1], zero[7:2]
    output logic [7:0]                     m_tdata,
    input  wire                            cfg_valid,
    output logic                           cfg_ready,
    input  wire  [dwnf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire  [63:0]                    cfg_data
);

    logic [63:0]           pattern_low_reg;
    logic [63:0]           pattern_high_reg;
    logic [4:0]            flags_reg;
    logic [31:0]           user_id_reg;
    logic [31:0]           group_id_reg;
    dwnf_pkg::filter_cfg_t filter_cfg;

    logic                  push_valid, push_ready;
    dwnf_pkg::entry_t      push_data;
    logic                  pop_valid, pop_ready;
    dwnf_pkg::entry_t      pop_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_low_reg  <= '0;
            pattern_high_reg <= '0;
            flags_reg        <= '0;
            user_id_reg      <= '0;
            group_id_reg     <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                dwnf_pkg::CFG_PATTERN_LOW:  pattern_low_reg  <= cfg_data;
                dwnf_pkg::CFG_PATTERN_HIGH: pattern_high_reg <= cfg_data;
                dwnf_pkg::CFG_FILTER_FLAGS: flags_reg        <= cfg_data[4:0];
                dwnf_pkg::CFG_USER_ID:      user_id_reg      <= cfg_data[31:0];
                dwnf_pkg::CFG_GROUP_ID:     group_id_reg     <= cfg_data[31:0];
                default: begin
                end
            endcase
        end
    end

    assign filter_cfg.flags    = flags_reg;
    assign filter_cfg.user_id  = user_id_reg;
    assign filter_cfg.group_id = group_id_reg;

    dwnf_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .s_tuser    (s_tuser),
        .cfg        (filter_cfg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    dwnf_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_data  (push_data),
        .rd_valid (pop_valid),
        .rd_ready (pop_ready),
        .rd_data  (pop_data)
    );

    dwnf_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pattern   ({pattern_high_reg, pattern_low_reg}),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

/* design/dwnf_front.sv */
// Front end: accepts name bytes, tracks the leading dot and evaluates the
// attribute filters on every byte; the matcher keeps the last. Depends on dwnf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dwnf_front (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_tvalid,
    output logic                 s_tready,
    input  wire  [87:0]          s_tdata,
    input  wire                  s_tlast,
    input  wire                  s_tuser,
    input  dwnf_pkg::filter_cfg_t cfg,
    output logic                 push_valid,
    input  wire                  push_ready,
    output dwnf_pkg::entry_t     push_data
);

    logic        first_reg, first_next;
    logic        sdot_reg, sdot_next;
    logic [7:0]  name_char;
    logic [15:0] file_mode;
    logic [31:0] owner_uid;
    logic [31:0] owner_gid;
    logic        dot_now;
    logic        uid_eq, gid_eq;
    logic        pass;
    logic        accept;

    function automatic logic perm_ok(input logic [15:0] mode, input logic [2:0] bits,
                                     input logic u_eq, input logic g_eq);
        perm_ok = (|(mode[2:0] & bits)) ||
                  ((|(mode[5:3] & bits)) && g_eq) ||
                  ((|(mode[8:6] & bits)) && u_eq);
    endfunction

    assign name_char = s_tdata[7:0];
    assign file_mode = s_tdata[23:8];
    assign owner_uid = s_tdata[55:24];
    assign owner_gid = s_tdata[87:56];

    assign s_tready   = push_ready;
    assign push_valid = s_tvalid;
    assign accept     = s_tvalid && push_ready;

    always_comb begin
        dot_now = first_reg ? (name_char == dwnf_pkg::CHAR_DOT) : sdot_reg;
        uid_eq  = (owner_uid == cfg.user_id);
        gid_eq  = (owner_gid == cfg.group_id);
        pass    = 1'b1;
        if (cfg.flags != 5'd0) begin
            if (!s_tuser)
                pass = 1'b0;
            if (cfg.flags[dwnf_pkg::FLAG_HIDE_DOT] && dot_now)
                pass = 1'b0;
            if (cfg.flags[dwnf_pkg::FLAG_MINE] && !uid_eq)
                pass = 1'b0;
            if (cfg.flags[dwnf_pkg::FLAG_ACCESS] &&
                !perm_ok(file_mode, dwnf_pkg::PERM_ANY, uid_eq, gid_eq))
                pass = 1'b0;
            if (cfg.flags[dwnf_pkg::FLAG_REGULAR] &&
                ((file_mode & dwnf_pkg::MODE_TYPE) != dwnf_pkg::MODE_REG))
                pass = 1'b0;
            if (cfg.flags[dwnf_pkg::FLAG_READ] &&
                !perm_ok(file_mode, dwnf_pkg::PERM_READ, uid_eq, gid_eq))
                pass = 1'b0;
        end
        push_data.name_char = name_char;
        push_data.is_last   = s_tlast;
        push_data.pass      = pass;
        first_next = first_reg;
        sdot_next  = sdot_reg;
        if (accept) begin
            first_next = s_tlast;
            sdot_next  = dot_now;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg <= 1'b1;
            sdot_reg  <= 1'b0;
        end else begin
            first_reg <= first_next;
            sdot_reg  <= sdot_next;
        end
    end

endmodule

`default_nettype wire

/* design/dwnf_queue.sv */
// Short FIFO between the front end and the matcher.
// Depends on dwnf_pkg for depth and entry type.
`timescale 1ns / 1ps
`default_nettype none

module dwnf_queue (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              wr_valid,
    output logic             wr_ready,
    input  dwnf_pkg::entry_t wr_data,
    output logic             rd_valid,
    input  wire              rd_ready,
    output dwnf_pkg::entry_t rd_data
);

    dwnf_pkg::entry_t                 mem_reg [dwnf_pkg::QUEUE_DEPTH];
    logic [dwnf_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [dwnf_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [dwnf_pkg::QCNT_W-1:0]      count_reg, count_next;
    logic                             do_wr, do_rd;

    function automatic logic [dwnf_pkg::QPTR_W-1:0] ptr_inc(
        input logic [dwnf_pkg::QPTR_W-1:0] ptr);
        if (ptr == dwnf_pkg::QPTR_W'(dwnf_pkg::QUEUE_DEPTH - 1))
            ptr_inc = '0;
        else
            ptr_inc = ptr + dwnf_pkg::QPTR_W'(1);
    endfunction

    assign wr_ready = (count_reg != dwnf_pkg::QCNT_W'(dwnf_pkg::QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = do_wr ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_rd ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
            count_next = count_reg + dwnf_pkg::QCNT_W'(1);
        else if (!do_wr && do_rd)
            count_next = count_reg - dwnf_pkg::QCNT_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= dwnf_pkg::QCNT_W'(dwnf_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

`default_nettype wire

/* design/dwnf_back.sv */
// Matcher: steps the wildcard pattern, at most one position a cycle, for each name byte,
// finishes the name and holds the result in the output register.
// Depends on dwnf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dwnf_back (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire  [127:0]     pattern,
    input  wire              pop_valid,
    output logic             pop_ready,
    input  dwnf_pkg::entry_t pop_data,
    output logic             m_tvalid,
    input  wire              m_tready,
    output logic [7:0]       m_tdata
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_FEED = 6'b000010,
        ST_DOT  = 6'b000100,
        ST_TAIL = 6'b001000,
        ST_FIN  = 6'b010000,
        ST_RES  = 6'b100000
    } state_t;

    state_t                     state_reg, state_next;
    logic [dwnf_pkg::POS_W-1:0] pos_reg, pos_next;
    logic                       star_reg, star_next;
    logic                       failed_reg, failed_next;
    logic                       ret_fin_reg, ret_fin_next;
    logic                       match_reg, match_next;
    logic [7:0]                 char_reg, char_next;
    logic                       last_reg, last_next;
    logic                       pass_reg, pass_next;
    logic                       m_valid_reg, m_valid_next;
    logic                       out_match_reg, out_match_next;
    logic                       out_acc_reg, out_acc_next;

    logic [15:0][7:0]           pat_bytes;
    logic [4:0]                 pos_ext;
    logic [7:0]                 p;
    logic                       eq;
    logic                       c_dot;
    logic [dwnf_pkg::POS_W-1:0] pos_inc;
    logic                       feed_done;

    function automatic logic [7:0] up(input logic [7:0] c);
        if (c inside {[8'h61:8'h7A]})
            up = c - 8'd32;
        else
            up = c;
    endfunction

    assign pat_bytes = pattern;
    assign pos_ext   = 5'(pos_reg);
    assign p         = (pos_reg < dwnf_pkg::POS_W'(dwnf_pkg::PATTERN_BYTES)) ?
                       pat_bytes[pos_ext[3:0]] : dwnf_pkg::CHAR_NUL;
    assign eq        = (char_reg != dwnf_pkg::CHAR_NUL) && (up(char_reg) == up(p));
    assign c_dot     = (char_reg == dwnf_pkg::CHAR_DOT);
    assign pos_inc   = pos_reg + dwnf_pkg::POS_W'(1);

    assign pop_ready = (state_reg == ST_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {6'b0, out_acc_reg, out_match_reg};

    always_comb begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        star_next      = star_reg;
        failed_next    = failed_reg;
        ret_fin_next   = ret_fin_reg;
        match_next     = match_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        pass_next      = pass_reg;
        out_match_next = out_match_reg;
        out_acc_next   = out_acc_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        feed_done      = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (pop_valid) begin
                    char_next  = pop_data.name_char;
                    last_next  = pop_data.is_last;
                    pass_next  = pop_data.pass;
                    state_next = ST_FEED;
                end
            end
            ST_FEED: begin
                if (failed_reg) begin
                    feed_done = 1'b1;
                end else if (star_reg) begin
                    if (c_dot) begin
                        star_next    = 1'b0;
                        ret_fin_next = 1'b0;
                        state_next   = ST_DOT;
                    end else begin
                        feed_done = 1'b1;
                    end
                end else if (eq) begin
                    pos_next  = pos_inc;
                    feed_done = 1'b1;
                end else if (p == dwnf_pkg::CHAR_STAR) begin
                    star_next = 1'b1;
                end else if (p == dwnf_pkg::CHAR_QMARK) begin
                    pos_next  = pos_inc;
                    feed_done = !c_dot;
                end else begin
                    failed_next = 1'b1;
                    feed_done   = 1'b1;
                end
                if (feed_done)
                    state_next = last_reg ? ST_FIN : ST_IDLE;
            end
            ST_DOT: begin
                if (p != dwnf_pkg::CHAR_DOT && p != dwnf_pkg::CHAR_NUL)
                    pos_next = pos_inc;
                else
                    state_next = ret_fin_reg ? ST_TAIL : ST_FEED;
            end
            ST_TAIL: begin
                if (p inside {dwnf_pkg::CHAR_QMARK, dwnf_pkg::CHAR_STAR,
                              dwnf_pkg::CHAR_DOT}) begin
                    pos_next = pos_inc;
                end else begin
                    if (p != dwnf_pkg::CHAR_NUL)
                        failed_next = 1'b1;
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (failed_reg) begin
                    match_next = 1'b0;
                    state_next = ST_RES;
                end else if (p == dwnf_pkg::CHAR_NUL) begin
                    match_next = 1'b1;
                    state_next = ST_RES;
                end else if (star_reg) begin
                    star_next    = 1'b0;
                    ret_fin_next = 1'b1;
                    state_next   = ST_DOT;
                end else if (p == dwnf_pkg::CHAR_STAR) begin
                    star_next = 1'b1;
                end else if (p == dwnf_pkg::CHAR_QMARK) begin
                    pos_next   = pos_inc;
                    state_next = ST_TAIL;
                end else begin
                    failed_next = 1'b1;
                end
            end
            ST_RES: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next   = 1'b1;
                    out_match_next = match_reg;
                    out_acc_next   = match_reg && pass_reg;
                    pos_next       = '0;
                    star_next      = 1'b0;
                    failed_next    = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        char_reg      <= char_next;
        last_reg      <= last_next;
        pass_reg      <= pass_next;
        match_reg     <= match_next;
        ret_fin_reg   <= ret_fin_next;
        out_match_reg <= out_match_next;
        out_acc_reg   <= out_acc_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pos_reg     <= '0;
            star_reg    <= 1'b0;
            failed_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            star_reg    <= star_next;
            failed_reg  <= failed_next;
            m_valid_reg <= m_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= dwnf_pkg::POS_W'(dwnf_pkg::PATTERN_BYTES))
        else $error("pattern position beyond pattern end");

    a_result_from_res: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_RES))
        else $error("result raised outside result state");

    a_tail_no_star: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TAIL) |-> !star_reg)
        else $error("tail skip entered with star pending");
`endif

endmodule

`default_nettype wire
